@@ rtl/core/sphp_pkg.sv @@
// space packet header parser package
// byte counts, secondary header lengths and sequence flag codes
// no dependencies
`default_nettype none

package sphp_pkg;

  localparam int unsigned POS_W = 5;

  localparam logic [10:0] APID_LIMIT_RESET = 11'd1449;

  localparam logic [POS_W-1:0] PRIMARY_END = 5'd6;
  localparam logic [POS_W-1:0] TIME_END    = 5'd14;
  localparam logic [POS_W-1:0] SEGMENT_END = 5'd16;

  localparam logic [3:0] SEC_LEN_FIRST = 4'd10;
  localparam logic [3:0] SEC_LEN_OTHER = 4'd8;

  typedef enum logic [1:0] {
    SEQ_MIDDLE     = 2'd0,
    SEQ_FIRST      = 2'd1,
    SEQ_LAST       = 2'd2,
    SEQ_STANDALONE = 2'd3
  } seq_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/space_packet_header_parser.sv @@
// space packet primary header parser, top level
// one header byte per transfer, one decoded header per completed header
// depends on sphp_pkg
// the result is registered: valid in the cycle after the last header byte is accepted
// one byte per cycle while in_ready is high; 6, 14 or 16 bytes per header
// the result register frees itself in the cycle it is taken, so no bubble
// reset: synchronous, clears byte position and result valid, sets expected
// length to 6 and loads apid_limit with 1449
`default_nettype none

module space_packet_header_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  header_byte,
  input  wire logic        start_of_header,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       version,
  output logic             has_secondary,
  output logic [10:0]      apid,
  output logic [1:0]       sequence_flags,
  output logic [13:0]      sequence_count,
  output logic [16:0]      data_length,
  output logic [15:0]      day_number,
  output logic [31:0]      milliseconds,
  output logic [15:0]      microseconds,
  output logic [7:0]       segment_count,
  output logic             header_valid
);

  logic [10:0]                    apid_limit;
  logic [sphp_pkg::POS_W-1:0]     byte_position;
  logic [sphp_pkg::POS_W-1:0]     expected_total;
  logic [47:0]                    primary_bytes;
  logic [63:0]                    time_bytes;
  logic [15:0]                    segment_word;

  logic                           in_xfer;
  logic                           active;
  logic [sphp_pkg::POS_W-1:0]     pos_cur;
  logic [sphp_pkg::POS_W-1:0]     pos_new;
  logic [sphp_pkg::POS_W-1:0]     exp_cur;
  logic [sphp_pkg::POS_W-1:0]     expected_total_next;
  logic [47:0]                    primary_bytes_next;
  logic [63:0]                    time_bytes_next;
  logic [15:0]                    segment_word_next;
  logic                           emit;

  logic [15:0]                    w0;
  logic [15:0]                    w1;
  logic [15:0]                    w2;
  logic                           sh;
  logic                           first_seg;
  logic [16:0]                    len_raw;
  logic [3:0]                     sub;
  logic                           underflow;
  logic [16:0]                    len_adj;
  logic                           valid_n;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign active  = start_of_header || (byte_position != '0);
  assign pos_cur = start_of_header ? '0 : byte_position;
  assign exp_cur = start_of_header ? sphp_pkg::PRIMARY_END : expected_total;
  assign pos_new = pos_cur + 1'b1;

  // shift the byte into the field its position belongs to
  always_comb begin
    primary_bytes_next = primary_bytes;
    time_bytes_next    = time_bytes;
    segment_word_next  = segment_word;
    if (pos_cur < sphp_pkg::PRIMARY_END) begin
      primary_bytes_next = {primary_bytes[39:0], header_byte};
    end else if (pos_cur < sphp_pkg::TIME_END) begin
      time_bytes_next = {time_bytes[55:0], header_byte};
    end else begin
      segment_word_next = {segment_word[7:0], header_byte};
    end
  end

  assign w0        = primary_bytes_next[47:32];
  assign w1        = primary_bytes_next[31:16];
  assign w2        = primary_bytes_next[15:0];
  assign sh        = w0[11];
  assign first_seg = (w1[15:14] == sphp_pkg::SEQ_FIRST);

  always_comb begin
    expected_total_next = exp_cur;
    if (pos_new == sphp_pkg::PRIMARY_END) begin
      if (!sh) begin
        expected_total_next = sphp_pkg::PRIMARY_END;
      end else if (first_seg) begin
        expected_total_next = sphp_pkg::SEGMENT_END;
      end else begin
        expected_total_next = sphp_pkg::TIME_END;
      end
    end
  end

  assign emit = active && (pos_new == expected_total_next);

  // length field plus one, less the secondary header, clamped at zero
  assign len_raw   = {1'b0, w2} + 17'd1;
  assign sub       = sh ? (first_seg ? sphp_pkg::SEC_LEN_FIRST : sphp_pkg::SEC_LEN_OTHER)
                        : 4'd0;
  assign underflow = (len_raw < {13'd0, sub});
  assign len_adj   = underflow ? 17'd0 : (len_raw - {13'd0, sub});

  assign valid_n = !underflow
                && (w0[15:13] == 3'd0)
                && (w0[10:0] <= apid_limit)
                && !len_adj[16]
                && (sh == (first_seg || (w1[15:14] == sphp_pkg::SEQ_STANDALONE)));

  always_ff @(posedge clk) begin
    if (rst) begin
      apid_limit <= sphp_pkg::APID_LIMIT_RESET;
    end else if (cfg_we) begin
      apid_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      expected_total <= sphp_pkg::PRIMARY_END;
    end else if (in_xfer && active) begin
      if (emit) begin
        byte_position  <= '0;
        expected_total <= sphp_pkg::PRIMARY_END;
      end else begin
        byte_position  <= pos_new;
        expected_total <= expected_total_next;
      end
    end
  end

  // header bytes are always fully rewritten before they are decoded
  always_ff @(posedge clk) begin
    if (in_xfer && active) begin
      primary_bytes <= primary_bytes_next;
      time_bytes    <= time_bytes_next;
      segment_word  <= segment_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      version        <= w0[15:13];
      has_secondary  <= sh;
      apid           <= w0[10:0];
      sequence_flags <= w1[15:14];
      sequence_count <= w1[13:0];
      data_length    <= len_adj;
      day_number     <= sh ? time_bytes_next[63:48] : 16'd0;
      milliseconds   <= sh ? time_bytes_next[47:16] : 32'd0;
      microseconds   <= sh ? time_bytes_next[15:0] : 16'd0;
      segment_count  <= (sh && first_seg) ? segment_word_next[15:8] : 8'd0;
      header_valid   <= valid_n;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sphp_checker.sv @@
// port-level checks for the space packet header parser
// bound to space_packet_header_parser; depends on sphp_pkg
`default_nettype none

module sphp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  version,
  input wire logic        has_secondary,
  input wire logic [10:0] apid,
  input wire logic [1:0]  sequence_flags,
  input wire logic [13:0] sequence_count,
  input wire logic [16:0] data_length,
  input wire logic [15:0] day_number,
  input wire logic [31:0] milliseconds,
  input wire logic [15:0] microseconds,
  input wire logic [7:0]  segment_count,
  input wire logic        header_valid
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(apid) && $stable(data_length)
      && $stable(milliseconds) && $stable(sequence_count) && $stable(header_valid))
    else $error("result changed while stalled");

  a_valid_version: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_valid |-> version == 3'd0)
    else $error("valid header with nonzero version");

  a_no_secondary_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_secondary |-> day_number == 16'd0 && milliseconds == 32'd0
      && microseconds == 16'd0 && segment_count == 8'd0)
    else $error("time fields set without secondary header");

  a_valid_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_valid |-> has_secondary ==
      (sequence_flags == sphp_pkg::SEQ_FIRST || sequence_flags == sphp_pkg::SEQ_STANDALONE))
    else $error("valid header with inconsistent secondary flag");

  a_valid_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_length[16] |-> !header_valid)
    else $error("valid header with oversize length");

endmodule

bind space_packet_header_parser sphp_checker u_sphp_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .version        (version),
  .has_secondary  (has_secondary),
  .apid           (apid),
  .sequence_flags (sequence_flags),
  .sequence_count (sequence_count),
  .data_length    (data_length),
  .day_number     (day_number),
  .milliseconds   (milliseconds),
  .microseconds   (microseconds),
  .segment_count  (segment_count),
  .header_valid   (header_valid)
);

`default_nettype wire
